@@ rtl/iwd_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// iwd_pkg
// Shared types, constants and fixed-point helpers for the iterated waveshaper.
// ============================================================================
package iwd_pkg;

    // Internal datapath: Q8.23, 31 bits signed
    localparam int QW   = 31;
    localparam int FRAC = 23;

    typedef logic signed [QW-1:0] t_q;
    typedef logic signed [63:0]   t_wide;

    localparam t_wide QMAX = 64'sd1073741823;
    localparam t_wide QMIN = -64'sd1073741824;

    // Shaper constants, rounded to 2^-23
    localparam t_q K_ONE      = 31'sd8388608;
    localparam t_q K_ONE_HALF = 31'sd12582912;
    localparam t_q K_HALF     = 31'sd4194304;
    localparam t_q K_LOW_TH   = -31'sd747006;
    localparam t_q K_OFFS     = 31'sd275541;
    localparam t_q K_HIGH_TH  = 31'sd2684506;
    localparam t_q K_QUAD     = -31'sd51615105;
    localparam t_q K_LIN      = 31'sd33030144;
    localparam t_q K_CEIL     = 31'sd5285117;
    localparam t_q K_BIAS     = -31'sd6207570;
    localparam t_q K_3Q       = 31'sd6291456;
    localparam t_q K_1Q       = 31'sd2097152;

    // Algorithm codes
    localparam logic [1:0] ALG_CUBIC = 2'd0;
    localparam logic [1:0] ALG_SYM   = 2'd1;
    localparam logic [1:0] ALG_ASYM  = 2'd2;
    localparam logic [1:0] ALG_ALT   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_GAIN  = 2'd0;
    localparam logic [1:0] REG_INTEN = 2'd1;
    localparam logic [1:0] REG_ALGO  = 2'd2;
    localparam logic [1:0] REG_WET   = 2'd3;

    // Per-pass curve segment
    typedef enum logic [2:0] {
        M_CUBIC,
        M_SYM,
        M_QUAD,
        M_ALOW,
        M_CEIL
    } t_mode;

    // Value handed from pass to pass: current value and the one before
    typedef struct packed {
        t_q x;
        t_q prev;
    } t_pair;

    function automatic t_q sat_q(input t_wide v);
        t_q r;
        if (v > QMAX) begin
            r = t_q'(QMAX);
        end else if (v < QMIN) begin
            r = t_q'(QMIN);
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    // Q8.23 multiply, round half up, saturate
    function automatic t_q mulq(input t_q a, input t_q b);
        logic signed [2*QW-1:0] p;
        t_wide s;
        p = a * b;
        s = t_wide'(p) + (64'sd1 <<< (FRAC - 1));
        return sat_q(s >>> FRAC);
    endfunction

    function automatic t_mode mode_of(input logic [1:0] alg, input t_q x);
        t_mode m;
        case (alg)
            ALG_CUBIC: m = M_CUBIC;
            ALG_SYM:   m = M_SYM;
            default: begin
                if (x < K_LOW_TH) begin
                    m = M_ALOW;
                end else if (x < K_HIGH_TH) begin
                    m = M_QUAD;
                end else begin
                    m = M_CEIL;
                end
            end
        endcase
        return m;
    endfunction

endpackage

@@ rtl/iwd_in_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// iwd_in_if
// Input channel: one stereo sample pair per item.
// ============================================================================
interface iwd_in_if #(
    parameter int SW = 24
);
    logic          valid;
    logic          ready;
    logic [SW-1:0] left_in;
    logic [SW-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

@@ rtl/iwd_out_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// iwd_out_if
// Output channel: one processed stereo sample pair per item.
// ============================================================================
interface iwd_out_if #(
    parameter int SW = 24
);
    logic          valid;
    logic          ready;
    logic [SW-1:0] left_out;
    logic [SW-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

@@ rtl/iwd_cell.sv @@
`timescale 1ns / 1ps
// ============================================================================
// iwd_cell
// One shaper pass for both channels, six pipeline stages deep. An inactive
// cell forwards its value unchanged.
// ============================================================================
module iwd_cell #(
    parameter int SW = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_active,
    input  logic [1:0]                i_algo,
    input  logic                      i_valid,
    input  iwd_pkg::t_pair [1:0]      i_data,
    input  logic [1:0][SW-1:0]        i_dry,
    output logic                      o_valid,
    output iwd_pkg::t_pair [1:0]      o_data,
    output logic [1:0][SW-1:0]        o_dry
);

    localparam int NS = 6;

    logic [NS-1:0]                r_v;
    iwd_pkg::t_q                  r_x    [2][NS];
    iwd_pkg::t_q                  r_prev [2][NS];
    iwd_pkg::t_q                  r_p1   [2][NS];
    iwd_pkg::t_q                  r_p2   [2][NS];
    iwd_pkg::t_q                  r_p3   [2][NS];
    logic [SW-1:0]                r_dry  [2][NS];

    iwd_pkg::t_q                  n_x    [2][NS];
    iwd_pkg::t_q                  n_prev [2][NS];
    iwd_pkg::t_q                  n_p1   [2][NS];
    iwd_pkg::t_q                  n_p2   [2][NS];
    iwd_pkg::t_q                  n_p3   [2][NS];
    logic [SW-1:0]                n_dry  [2][NS];

    // Stage logic: stage 0 squares, later stages finish the selected curve
    always_comb begin
        iwd_pkg::t_q   x, pv, p1, p2, p3, iv, b, ma, mb, t, mm;
        iwd_pkg::t_wide ax;
        iwd_pkg::t_mode m;
        logic [SW-1:0] d;
        for (int c = 0; c < 2; c++) begin
            for (int s = 0; s < NS; s++) begin
                if (s == 0) begin
                    x  = i_data[c].x;
                    pv = i_data[c].prev;
                    p1 = '0;
                    p2 = '0;
                    p3 = '0;
                    d  = i_dry[c];
                end else begin
                    x  = r_x[c][s-1];
                    pv = r_prev[c][s-1];
                    p1 = r_p1[c][s-1];
                    p2 = r_p2[c][s-1];
                    p3 = r_p3[c][s-1];
                    d  = r_dry[c][s-1];
                end
                m  = iwd_pkg::mode_of(i_algo, x);
                iv = '0;
                b  = '0;
                ma = '0;
                mb = '0;
                t  = '0;
                mm = '0;
                ax = '0;
                n_x[c][s]    = x;
                n_prev[c][s] = pv;
                n_dry[c][s]  = d;
                n_p1[c][s]   = p1;
                n_p2[c][s]   = p2;
                n_p3[c][s]   = p3;
                case (s)
                    0: begin
                        // x*x, or (1-i)^2 for the low asymmetric segment
                        iv = iwd_pkg::sat_q(-iwd_pkg::t_wide'(x)
                                            - iwd_pkg::t_wide'(iwd_pkg::K_OFFS));
                        b  = iwd_pkg::sat_q(iwd_pkg::t_wide'(iwd_pkg::K_ONE)
                                            - iwd_pkg::t_wide'(iv));
                        ma = (m == iwd_pkg::M_ALOW) ? b : x;
                        n_p1[c][s] = iwd_pkg::mulq(ma, ma);
                        n_p2[c][s] = (m == iwd_pkg::M_ALOW) ? iv
                                   : iwd_pkg::mulq(iwd_pkg::K_LIN, x);
                    end
                    1: begin
                        case (m)
                            iwd_pkg::M_CUBIC: mb = iwd_pkg::K_HALF;
                            iwd_pkg::M_QUAD:  mb = iwd_pkg::K_QUAD;
                            default:          mb = p1;
                        endcase
                        ax = (x < 0) ? -iwd_pkg::t_wide'(x) : iwd_pkg::t_wide'(x);
                        mm = iwd_pkg::sat_q(
                                 iwd_pkg::t_wide'(iwd_pkg::sat_q(ax <<< 1))
                                 - iwd_pkg::t_wide'(p1));
                        case (m)
                            iwd_pkg::M_SYM: begin
                                if (x < 0) begin
                                    n_p1[c][s] = -mm;
                                end else if (x > 0) begin
                                    n_p1[c][s] = mm;
                                end else begin
                                    n_p1[c][s] = '0;
                                end
                            end
                            iwd_pkg::M_CEIL: n_p1[c][s] = iwd_pkg::K_CEIL;
                            default:         n_p1[c][s] = iwd_pkg::mulq(p1, mb);
                        endcase
                    end
                    2: begin
                        t  = iwd_pkg::sat_q(iwd_pkg::t_wide'(iwd_pkg::K_ONE_HALF)
                                            - iwd_pkg::t_wide'(p1));
                        ma = (m == iwd_pkg::M_CUBIC) ? x : p1;
                        mb = (m == iwd_pkg::M_CUBIC) ? t : p1;
                        case (m)
                            iwd_pkg::M_CUBIC: n_p1[c][s] = iwd_pkg::mulq(ma, mb);
                            iwd_pkg::M_ALOW: begin
                                n_p3[c][s] = p1;
                                n_p1[c][s] = iwd_pkg::mulq(ma, mb);
                            end
                            iwd_pkg::M_QUAD: begin
                                n_p1[c][s] = iwd_pkg::sat_q(iwd_pkg::t_wide'(p1)
                                                            + iwd_pkg::t_wide'(p2));
                            end
                            default: ;
                        endcase
                    end
                    3: begin
                        // b12 = b8 * b4
                        if (m == iwd_pkg::M_ALOW) begin
                            n_p1[c][s] = iwd_pkg::mulq(p1, p3);
                        end
                    end
                    4: begin
                        if (m == iwd_pkg::M_ALOW) begin
                            n_p1[c][s] = iwd_pkg::mulq(iwd_pkg::K_3Q, p1);
                            n_p2[c][s] = iwd_pkg::mulq(iwd_pkg::K_1Q, p2);
                        end
                    end
                    default: begin
                        if (m == iwd_pkg::M_ALOW) begin
                            n_p1[c][s] = iwd_pkg::sat_q(
                                iwd_pkg::t_wide'(iwd_pkg::sat_q(
                                    iwd_pkg::t_wide'(iwd_pkg::K_BIAS)
                                    + iwd_pkg::t_wide'(p1)))
                                - iwd_pkg::t_wide'(p2));
                        end
                    end
                endcase
            end
        end
    end

    // Stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_prev <= n_prev;
            r_p1   <= n_p1;
            r_p2   <= n_p2;
            r_p3   <= n_p3;
            r_dry  <= n_dry;
        end
    end

    // Hand-off to the next pass
    always_comb begin
        o_valid = r_v[NS-1];
        for (int c = 0; c < 2; c++) begin
            o_dry[c]       = r_dry[c][NS-1];
            o_data[c].x    = i_active ? r_p1[c][NS-1] : r_x[c][NS-1];
            o_data[c].prev = i_active ? r_x[c][NS-1]  : r_prev[c][NS-1];
        end
    end

endmodule

@@ rtl/iterated_waveshaper_distortion.sv @@
`timescale 1ns / 1ps
// ============================================================================
// iterated_waveshaper_distortion
// Stereo distortion: input gain, repeated waveshaping, blend and dry/wet mix.
// ============================================================================
// Usage:
//   i_in carries one stereo pair (left_in, right_in) per item, o_out one
//   processed pair (left_out, right_out). Both use valid/ready; an item moves
//   when both are high.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while the
//   block holds no items: 0 input gain, 1 intensity, 2 algorithm, 3 wet mix.
//   The pipeline holds one gain stage, six stages per shaper cell, one blend
//   stage and the output register. Every cell is always present; cells past
//   the pass count forward their value. Throughput is one item per cycle
//   while o_out is not stalled, set by the fully pipelined cell chain.
//   When the receiver stalls, the pipeline keeps filling until the blend
//   stage holds an item behind the waiting output; then i_in.ready drops.
//   Reset clears all pipeline valid bits and loads the register defaults
//   (unity gain, intensity 0, cubic curve, fully dry).
// ============================================================================
module iterated_waveshaper_distortion #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_PASSES  = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iwd_in_if.sink      i_in,
    iwd_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data
);

    localparam logic [11:0] CAP    = 12'((MAX_PASSES - 1) * 256);
    localparam logic [16:0] W_FULL = 17'd65536;
    localparam iwd_pkg::t_wide SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam iwd_pkg::t_wide SMIN = -SMAX - 64'sd1;

    // Configuration registers
    logic [14:0] r_gain;
    logic [11:0] r_inten;
    logic [1:0]  r_algo;
    logic [16:0] r_wet;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= 15'd8192;
            r_inten <= '0;
            r_algo  <= iwd_pkg::ALG_CUBIC;
            r_wet   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                iwd_pkg::REG_GAIN:  r_gain  <= i_cfg_data[14:0];
                iwd_pkg::REG_INTEN: r_inten <= i_cfg_data[11:0];
                iwd_pkg::REG_ALGO:  r_algo  <= (i_cfg_data[1:0] == iwd_pkg::ALG_ALT)
                                               ? iwd_pkg::ALG_ASYM : i_cfg_data[1:0];
                iwd_pkg::REG_WET:   r_wet   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Derived controls
    logic [11:0] inten_c;
    logic [3:0]  last_pass;
    logic [7:0]  frac;
    logic [16:0] w_c;

    assign inten_c   = (r_inten > CAP) ? CAP : r_inten;
    assign last_pass = inten_c[11:8];
    assign frac      = inten_c[7:0];
    assign w_c       = (r_wet > W_FULL) ? W_FULL : r_wet;

    // Pipeline flow
    logic r_ovalid;
    logic r_b_v;
    logic en;

    assign en         = !r_b_v || !r_ovalid || o_out.ready;
    assign i_in.ready = en;

    // Gain stage
    logic                          r_f_v;
    iwd_pkg::t_pair [1:0]          r_f_data;
    logic [1:0][SAMPLE_BITS-1:0]   r_f_dry;
    iwd_pkg::t_pair [1:0]          n_f_data;
    logic [1:0][SAMPLE_BITS-1:0]   in_dry;

    assign in_dry[0] = i_in.left_in;
    assign in_dry[1] = i_in.right_in;

    always_comb begin
        iwd_pkg::t_q    xs;
        iwd_pkg::t_wide g;
        for (int c = 0; c < 2; c++) begin
            xs = iwd_pkg::sat_q(iwd_pkg::t_wide'(signed'(in_dry[c])));
            g  = signed'(64'(r_gain));
            n_f_data[c].x    = iwd_pkg::sat_q((iwd_pkg::t_wide'(xs) * g + 64'sd4096) >>> 13);
            n_f_data[c].prev = n_f_data[c].x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (en) begin
            r_f_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_data <= n_f_data;
            r_f_dry  <= in_dry;
        end
    end

    // Chain of shaper cells
    logic                        c_v    [MAX_PASSES+1];
    iwd_pkg::t_pair [1:0]        c_data [MAX_PASSES+1];
    logic [1:0][SAMPLE_BITS-1:0] c_dry  [MAX_PASSES+1];

    assign c_v[0]    = r_f_v;
    assign c_data[0] = r_f_data;
    assign c_dry[0]  = r_f_dry;

    for (genvar k = 0; k < MAX_PASSES; k++) begin : g_cell
        iwd_cell #(
            .SW (SAMPLE_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_active (4'(k) <= last_pass),
            .i_algo   (r_algo),
            .i_valid  (c_v[k]),
            .i_data   (c_data[k]),
            .i_dry    (c_dry[k]),
            .o_valid  (c_v[k+1]),
            .o_data   (c_data[k+1]),
            .o_dry    (c_dry[k+1])
        );
    end

    // Blend of the last two passes
    iwd_pkg::t_q                 r_b_wet [2];
    logic [1:0][SAMPLE_BITS-1:0] r_b_dry;
    iwd_pkg::t_q                 n_b_wet [2];

    always_comb begin
        iwd_pkg::t_wide fw, fp;
        fw = signed'(64'(frac));
        fp = 64'sd256 - fw;
        for (int c = 0; c < 2; c++) begin
            n_b_wet[c] = iwd_pkg::sat_q(
                (iwd_pkg::t_wide'(c_data[MAX_PASSES][c].prev) * fp
                 + iwd_pkg::t_wide'(c_data[MAX_PASSES][c].x) * fw + 64'sd128) >>> 8);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= c_v[MAX_PASSES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_wet <= n_b_wet;
            r_b_dry <= c_dry[MAX_PASSES];
        end
    end

    // Dry/wet mix into the output register
    logic [SAMPLE_BITS-1:0] r_out [2];
    logic [SAMPLE_BITS-1:0] n_out [2];

    always_comb begin
        iwd_pkg::t_wide ww, wd, r;
        ww = signed'(64'(w_c));
        wd = 64'sd65536 - ww;
        for (int c = 0; c < 2; c++) begin
            r = (iwd_pkg::t_wide'(signed'(r_b_dry[c])) * wd
                 + iwd_pkg::t_wide'(r_b_wet[c]) * ww + 64'sd32768) >>> 16;
            if (r > SMAX) begin
                r = SMAX;
            end else if (r < SMIN) begin
                r = SMIN;
            end
            n_out[c] = r[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en && r_b_v) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_b_v) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.left_out  = r_out[0];
    assign o_out.right_out = r_out[1];

`ifndef SYNTHESIS
    // Input stalls only when both blend stage and output register are full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_b_v && r_ovalid && !o_out.ready))
        else $error("input stalled with room in the pipeline");

    // The alternate algorithm code is folded onto the asymmetric curve
    a_algo_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_algo != iwd_pkg::ALG_ALT)
        else $error("algorithm register holds unfolded code");

    // Pass count never exceeds the number of cells
    a_pass_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(last_pass) + 32'd1) <= 32'(MAX_PASSES))
        else $error("pass count beyond the cell chain");

    // A new result only comes out of a valid blend stage
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_b_v && en))
        else $error("output valid without a blended item");
`endif

endmodule
